[hw/rtl/mtbd_pkg.sv]
package mtbd_pkg;

   localparam int STATE_WORDS = 624;
   localparam int SHIFT_WORDS = 397;
   localparam int IDX_W       = $clog2(STATE_WORDS);
   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WORD_W-1:0] SEED_RESET  = 32'd5489;
   localparam logic [WORD_W-1:0] FILL_MULT   = 32'd1812433253;
   localparam logic [WORD_W-1:0] TWIST_XOR   = 32'h9908b0df;
   localparam logic [WORD_W-1:0] TEMPER_B    = 32'h9d2c5680;
   localparam logic [WORD_W-1:0] TEMPER_C    = 32'hefc60000;
   localparam logic [WORD_W-1:0] UPPER_MASK  = 32'h80000000;
   localparam logic [WORD_W-1:0] LOWER_MASK  = 32'h7fffffff;

   localparam logic OP_DRAW   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   typedef struct packed {
      logic              reseed;
      logic              full_word;
      logic [WORD_W-1:0] bound;
      logic [WORD_W-1:0] mask;
   } item_type;

   function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] m;
      m = b;
      m = m | (m >> 1);
      m = m | (m >> 2);
      m = m | (m >> 4);
      m = m | (m >> 8);
      m = m | (m >> 16);
      return m;
   endfunction

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                               input logic [WORD_W-1:0] nxt,
                                               input logic [WORD_W-1:0] far);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] w;
      y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
      w = far ^ (y >> 1);
      if (nxt[0]) begin
         w = w ^ TWIST_XOR;
      end
      return w;
   endfunction

endpackage

[hw/rtl/mtbd_ram.sv]
module mtbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[hw/rtl/mtbd_front.sv]
module mtbd_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_opcode,
   input  logic [mtbd_pkg::WORD_W-1:0] req_bound,
   output logic                       push_valid,
   input  logic                       push_ready,
   output mtbd_pkg::item_type         push_item
);

   // A zero bound draws the whole word, so the mask is forced to all ones.
   always_comb begin
      push_item.reseed    = (req_opcode == mtbd_pkg::OP_RESEED);
      push_item.full_word = (req_bound == '0);
      push_item.bound     = req_bound;
      push_item.mask      = (req_bound == '0) ? '1 : mtbd_pkg::smear(req_bound);
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

[hw/rtl/mtbd_queue.sv]
module mtbd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mtbd_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mtbd_pkg::item_type pop_item
);

   localparam int PTR_W = (mtbd_pkg::QUEUE_DEPTH > 1) ? $clog2(mtbd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mtbd_pkg::QUEUE_DEPTH + 1);

   mtbd_pkg::item_type slot_ff [mtbd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(mtbd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(mtbd_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(mtbd_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[hw/rtl/mtbd_back.sv]
module mtbd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mtbd_pkg::WORD_W-1:0] seed,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  mtbd_pkg::item_type          pop_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mtbd_pkg::WORD_W-1:0] rsp_value
);

   localparam int IW = mtbd_pkg::IDX_W;
   localparam int WW = mtbd_pkg::WORD_W;

   typedef enum logic [2:0] {
      S_FILL,
      S_IDLE,
      S_RG_PRIME,
      S_RG_CAPTURE,
      S_RG_READ,
      S_RG_WRITE,
      S_DR_READ,
      S_DR_TEMPER
   } state_type;

   state_type        state_ff;
   logic             check_ff;
   logic [IW-1:0]    k_ff;
   logic [IW-1:0]    pos_ff;
   logic [WW-1:0]    prev_ff;
   logic [WW-1:0]    cur_ff;
   logic [WW-1:0]    cand_ff;
   logic             full_ff;
   logic [WW-1:0]    bound_ff;
   logic [WW-1:0]    mask_ff;
   logic             rsp_valid_ff;
   logic [WW-1:0]    rsp_value_ff;

   logic             wr_en;
   logic [WW-1:0]    wr_data;
   logic [WW-1:0]    fill_word;
   logic [WW-1:0]    twist_word;
   logic [IW-1:0]    rd_a_addr;
   logic [IW-1:0]    next_idx;
   logic [IW:0]      far_sum;
   logic [IW-1:0]    far_idx;
   logic [WW-1:0]    rd_a_data;
   logic [WW-1:0]    rd_b_data;
   logic             last_k;
   logic             exhausted;
   logic             accept_cand;
   logic             rsp_load;

   assign last_k    = (k_ff == IW'(mtbd_pkg::STATE_WORDS - 1));
   assign exhausted = (pos_ff >= IW'(mtbd_pkg::STATE_WORDS));
   assign next_idx  = last_k ? '0 : k_ff + 1'b1;
   assign far_sum   = {1'b0, k_ff} + (IW+1)'(mtbd_pkg::SHIFT_WORDS);
   assign far_idx   = (far_sum >= (IW+1)'(mtbd_pkg::STATE_WORDS))
                      ? IW'(far_sum - (IW+1)'(mtbd_pkg::STATE_WORDS)) : far_sum[IW-1:0];

   assign fill_word  = (k_ff == '0) ? seed
                       : WW'(mtbd_pkg::FILL_MULT * (prev_ff ^ (prev_ff >> 30)))
                         + WW'(k_ff);
   assign twist_word = mtbd_pkg::twist(cur_ff, rd_a_data, rd_b_data);

   always_comb begin
      wr_en   = (state_ff == S_FILL) || (state_ff == S_RG_WRITE);
      wr_data = (state_ff == S_FILL) ? fill_word : twist_word;
      unique case (state_ff)
         S_RG_CAPTURE, S_RG_READ: rd_a_addr = next_idx;
         S_DR_READ:               rd_a_addr = pos_ff;
         default:                 rd_a_addr = '0;
      endcase
   end

   assign accept_cand = full_ff || (cand_ff < bound_ff);
   assign rsp_load    = (state_ff == S_IDLE) && check_ff && accept_cand
                        && (!rsp_valid_ff || rsp_ready);
   assign pop_ready   = (state_ff == S_IDLE) && !check_ff;

   mtbd_ram #(
      .WIDTH(WW),
      .DEPTH(mtbd_pkg::STATE_WORDS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (k_ff),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (far_idx),
      .rd_b_data (rd_b_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         check_ff     <= 1'b0;
         k_ff         <= '0;
         pos_ff       <= IW'(mtbd_pkg::STATE_WORDS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_FILL: begin
               prev_ff <= fill_word;
               if (last_k) begin
                  pos_ff   <= IW'(mtbd_pkg::STATE_WORDS);
                  state_ff <= S_IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_IDLE: begin
               // The idle state doubles as the accept/reject step of a draw.
               if (check_ff) begin
                  if (accept_cand) begin
                     // A finished draw waits here while the previous result is still held.
                     if (rsp_load) begin
                        check_ff     <= 1'b0;
                        rsp_value_ff <= cand_ff;
                     end
                  end else begin
                     check_ff <= 1'b0;
                     state_ff <= S_DR_READ;
                  end
               end else if (pop_valid && pop_ready) begin
                  if (pop_item.reseed) begin
                     k_ff     <= '0;
                     state_ff <= S_FILL;
                  end else begin
                     full_ff  <= pop_item.full_word;
                     bound_ff <= pop_item.bound;
                     mask_ff  <= pop_item.mask;
                     state_ff <= S_DR_READ;
                  end
               end
            end
            S_RG_PRIME: begin
               k_ff     <= '0;
               state_ff <= S_RG_CAPTURE;
            end
            S_RG_CAPTURE: begin
               cur_ff   <= rd_a_data;
               state_ff <= S_RG_WRITE;
            end
            S_RG_READ: begin
               state_ff <= S_RG_WRITE;
            end
            S_RG_WRITE: begin
               // The next word read here is the current word of the following step.
               cur_ff <= rd_a_data;
               if (last_k) begin
                  pos_ff   <= '0;
                  state_ff <= S_DR_READ;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_RG_READ;
               end
            end
            S_DR_READ: begin
               if (exhausted) begin
                  state_ff <= S_RG_PRIME;
               end else begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= S_DR_TEMPER;
               end
            end
            S_DR_TEMPER: begin
               cand_ff  <= mtbd_pkg::temper(rd_a_data) & mask_ff;
               check_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[hw/rtl/mersenne_twister_bounded_draw_core.sv]
// Draw path: each candidate word passes the read, temper and accept/reject steps from
// leaving the queue until the result is valid; an in-place regeneration runs every
// 624 words read. Flow: one item in flight in the engine; the next item is taken
// only after the take, read, temper and compare steps on the single state memory.
// Reset: synchronous; the state memory is then filled from the seed, one word a
// cycle, before the first request is served (requests still queue).
module mersenne_twister_bounded_draw_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_bound,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [mtbd_pkg::WORD_W-1:0] seed_ff;
   logic                        push_valid;
   logic                        push_ready;
   mtbd_pkg::item_type          push_item;
   logic                        pop_valid;
   logic                        pop_ready;
   mtbd_pkg::item_type          pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mtbd_pkg::SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   mtbd_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_bound  (req_bound),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   mtbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mtbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

endmodule

[hw/rtl/mtbd_checker.sv]
module mtbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value
);

   // A held response must keep its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response changed while stalled");

   // The store is being seeded after reset, so no response can show up early.
   a_no_early_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response during seeding");

   // The request queue is empty after reset and takes requests at once.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

endmodule

bind mersenne_twister_bounded_draw_core mtbd_checker u_mtbd_checker (.*);

[test/testbench.sv]
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int RANDOM_DRAWS  = 530;
   localparam int SETTLE_CYCLES = 3000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [31:0] req_bound;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_value;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   mersenne_twister_bounded_draw_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_bound   (req_bound),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the generator state.
   logic [31:0] mt_words [mtbd_pkg::STATE_WORDS];
   int unsigned mt_pos;
   logic [31:0] mt_seed;

   logic [31:0] draw_queue [$];
   int          error_count;
   int          cycle_count;
   bit          quiet_phase;
   bit          hold_rsp;

   typedef struct {
      logic        opcode;
      logic [31:0] bound;
      bit          known;
      logic [31:0] value;
   } stim_row;

   function automatic void mt_fill(input logic [31:0] s);
      mt_words[0] = s;
      for (int k = 1; k < mtbd_pkg::STATE_WORDS; k++) begin
         mt_words[k] = 32'd1812433253 * (mt_words[k-1] ^ (mt_words[k-1] >> 30)) + k;
      end
      mt_pos = mtbd_pkg::STATE_WORDS;
   endfunction

   function automatic logic [31:0] mt_next();
      logic [31:0] y;
      logic [31:0] nx;
      if (mt_pos >= mtbd_pkg::STATE_WORDS) begin
         for (int k = 0; k < mtbd_pkg::STATE_WORDS; k++) begin
            nx = mt_words[(k + 1) % mtbd_pkg::STATE_WORDS];
            y = (mt_words[k] & 32'h80000000) | (nx & 32'h7fffffff);
            y = mt_words[(k + mtbd_pkg::SHIFT_WORDS) % mtbd_pkg::STATE_WORDS] ^ (y >> 1);
            if (nx[0]) begin
               y = y ^ 32'h9908b0df;
            end
            mt_words[k] = y;
         end
         mt_pos = 0;
      end
      y = mt_words[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Returns 1 when the request produces a drawn value.
   function automatic bit mt_request(input logic op, input logic [31:0] bnd,
                                     output logic [31:0] v);
      logic [31:0] m;
      v = '0;
      if (op == mtbd_pkg::OP_RESEED) begin
         mt_fill(mt_seed);
         return 0;
      end
      if (bnd == 0) begin
         v = mt_next();
         return 1;
      end
      m = bnd;
      for (int s = 1; s < 32; s = s * 2) begin
         m = m | (m >> s);
      end
      do begin
         v = mt_next() & m;
      end while (v >= bnd);
      return 1;
   endfunction

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (draw_queue.size() == 0) begin
            $error("unexpected result value %h", rsp_value);
            error_count++;
         end else begin
            if (rsp_value !== draw_queue[0]) begin
               $error("value: expected %h, actual %h", draw_queue[0], rsp_value);
               error_count++;
            end
            void'(draw_queue.pop_front());
         end
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < 400; i++) begin
               @(negedge clock);
            end
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 8);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge clock);
         end
      end
   end

   // A known row expects its typed-in value; other rows expect the predictor's value.
   task automatic send_request(input logic op, input logic [31:0] bnd,
                               input bit known, input logic [31:0] kv);
      logic [31:0] v;
      int          gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_bound  <= bnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (mt_request(op, bnd, v)) begin
         draw_queue.push_back(known ? kv : v);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (draw_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] s);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mt_seed = s;
   endtask

   task automatic random_draw();
      logic [31:0] b;
      case ($urandom_range(0, 5))
         0: b = 0;
         1: b = $urandom_range(1, 16);
         2: b = 32'h1 << $urandom_range(0, 31);
         3: b = (32'h1 << $urandom_range(0, 31)) + 1;
         default: b = $urandom();
      endcase
      send_request(mtbd_pkg::OP_DRAW, b, 1'b0, '0);
   endtask

   stim_row rows [$];
   logic [31:0] seeds [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678, 32'h8000_0001};

   initial begin
      error_count = 0;
      cycle_count = 0;
      quiet_phase = 0;
      hold_rsp    = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = mtbd_pkg::OP_DRAW;
      req_bound   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      mt_seed     = mtbd_pkg::SEED_RESET;
      mt_fill(mt_seed);
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Known first outputs of the standard generator seeded with 5489.
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h0, 1, 32'd3499211612});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h0, 1, 32'd581869302});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h1, 1, 32'd0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'hffff_ffff, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h8000_0000, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h8000_0001, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h2, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h3, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h7fff_ffff, 0, 0});
      rows.push_back('{mtbd_pkg::OP_RESEED, 32'hffff_ffff, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h0, 1, 32'd3499211612});
      rows.push_back('{mtbd_pkg::OP_RESEED, 32'h0, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h5, 0, 0});
      rows.push_back('{mtbd_pkg::OP_DRAW, 32'h0, 0, 0});
      foreach (rows[i]) begin
         send_request(rows[i].opcode, rows[i].bound, rows[i].known, rows[i].value);
      end
      drain();

      // Random part: several seed settings, with a long receiver hold-off in one.
      for (int p = 0; p < 4; p++) begin
         write_seed(seeds[p]);
         send_request(mtbd_pkg::OP_RESEED, $urandom(), 1'b0, '0);
         if (p == 1) hold_rsp = 1;
         if (p == 3) quiet_phase = 1;
         for (int i = 0; i < RANDOM_DRAWS / 4; i++) begin
            if ($urandom_range(0, 60) == 0) begin
               send_request(mtbd_pkg::OP_RESEED, $urandom(), 1'b0, '0);
            end else begin
               random_draw();
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/mtbd_pkg.sv
hw/rtl/mtbd_ram.sv
hw/rtl/mtbd_front.sv
hw/rtl/mtbd_queue.sv
hw/rtl/mtbd_back.sv
hw/rtl/mersenne_twister_bounded_draw_core.sv
hw/rtl/mtbd_checker.sv
test/testbench.sv
